FILE: rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion macros shared by the rtl
// depends on a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ctpe_pkg.sv
// ctpe_pkg: types, constants and helpers of the capture tcp payload extractor
// no dependencies; used by the channel interfaces and the top level
package ctpe_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [5:0]  hdr_len_t;

  // reset value of the link header length register
  localparam byte_t    LINK_HDR_RESET = 8'd14;
  // default ip / tcp header length (five 32-bit words)
  localparam hdr_len_t HDR_LEN_DEFAULT = 6'd20;
  localparam logic [3:0] HDR_MIN_WORDS = 4'd5;
  // record header bytes that carry the included length
  localparam word_t    INCL_LEN_FIRST = 32'd8;
  localparam word_t    INCL_LEN_LAST  = 32'd11;
  // tcp byte that holds the data offset nibble
  localparam logic [8:0] TCP_DOFF_BYTE = 9'd12;

  // header length in bytes from a 4-bit word count, short counts clamp to five words
  function automatic hdr_len_t hdr_len_from_nibble(input logic [3:0] nib);
    hdr_len_t len;
    if (nib < HDR_MIN_WORDS) begin
      len = HDR_LEN_DEFAULT;
    end else begin
      len = {nib, 2'b00};
    end
    return len;
  endfunction

endpackage

FILE: rtl/ctpe_in_if.sv
// ctpe_in_if: valid/ready channel that carries capture stream items
// depends on ctpe_pkg for the byte type
interface ctpe_in_if;
  logic            valid;
  logic            ready;
  ctpe_pkg::byte_t in_byte;
  logic            capture_end;

  modport source (output valid, output in_byte, output capture_end, input ready);
  modport sink   (input valid, input in_byte, input capture_end, output ready);
endinterface

FILE: rtl/ctpe_out_if.sv
// ctpe_out_if: valid/ready channel that carries tcp payload items
// depends on ctpe_pkg for the byte type
interface ctpe_out_if;
  logic            valid;
  logic            ready;
  ctpe_pkg::byte_t payload_byte;
  logic            payload_last;

  modport source (output valid, output payload_byte, output payload_last, input ready);
  modport sink   (input valid, input payload_byte, input payload_last, output ready);
endinterface

FILE: rtl/capture_tcp_payload_extractor.sv
// capture_tcp_payload_extractor: pulls tcp payload bytes out of a capture byte stream
// depends on ctpe_pkg, ctpe_in_if, ctpe_out_if and assert_macros.svh
//
//   channel  dir  handshake            carries
//   in_ch    in   valid/ready          in_byte, capture_end
//   out_ch   out  valid/ready          payload_byte, payload_last
//   cfg_*    in   write enable only    link header length (8 bit)
//
// one item per cycle sustained while out_ch does not stall; an accepted item sits in the
// input register, then the parse step loads payload items into the output register, from
// which out_ch presents them
// rst_n is synchronous; reset restores the file header phase and a link header of 14
// a stall on out_ch holds the input register, and in_ch.ready drops once it is full
`include "assert_macros.svh"

module capture_tcp_payload_extractor #(
  parameter int FILE_HEADER_LEN   = 24,
  parameter int RECORD_HEADER_LEN = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  ctpe_in_if.sink           in_ch,
  ctpe_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  ctpe_pkg::byte_t   cfg_wr_data
);

  typedef enum logic [1:0] {
    PH_FILE,
    PH_REC,
    PH_BODY
  } phase_t;

  localparam ctpe_pkg::word_t FILE_HDR_END = 32'(FILE_HEADER_LEN);
  localparam ctpe_pkg::word_t REC_HDR_END  = 32'(RECORD_HEADER_LEN);

  // configuration
  ctpe_pkg::byte_t  link_len_r, link_len_nxt;

  // input register
  logic             s1_valid_r, s1_valid_nxt;
  ctpe_pkg::byte_t  s1_byte_r, s1_byte_nxt;
  logic             s1_end_r, s1_end_nxt;

  // parser state
  phase_t             phase_r, phase_nxt;
  ctpe_pkg::word_t    offset_r, offset_nxt;
  ctpe_pkg::word_t    rec_len_r, rec_len_nxt;
  ctpe_pkg::hdr_len_t ip_len_r, ip_len_nxt;
  ctpe_pkg::hdr_len_t tcp_len_r, tcp_len_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  ctpe_pkg::byte_t  out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  // handshake and step signals
  logic               in_fire;
  logic               s1_fire;
  logic               out_free;
  logic               emit;
  logic               emit_last;
  phase_t             cur_phase;
  ctpe_pkg::word_t    cur_off;
  ctpe_pkg::hdr_len_t cur_ip;
  ctpe_pkg::hdr_len_t cur_tcp;
  ctpe_pkg::word_t    off_inc;
  ctpe_pkg::word_t    len_m1;
  logic [8:0]         tcp_at;
  logic [8:0]         pay_at;

  // handshake
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.payload_last = out_last_r;

  // input register load
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    s1_end_nxt   = s1_end_r;
    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_ch.in_byte;
      s1_end_nxt   = in_ch.capture_end;
    end
  end

  // configuration write
  assign link_len_nxt = cfg_wr_en ? cfg_wr_data : link_len_r;

  // parse step on the item held in the input register
  always_comb begin
    // a spent file header (empty header length) starts the first record at once
    cur_phase = phase_r;
    cur_off   = offset_r;
    cur_ip    = ip_len_r;
    cur_tcp   = tcp_len_r;
    if (phase_r == PH_FILE && offset_r >= FILE_HDR_END) begin
      cur_phase = PH_REC;
      cur_off   = '0;
      cur_ip    = ctpe_pkg::HDR_LEN_DEFAULT;
      cur_tcp   = ctpe_pkg::HDR_LEN_DEFAULT;
    end

    off_inc     = cur_off + 32'd1;
    len_m1      = rec_len_r - 32'd1;
    phase_nxt   = cur_phase;
    offset_nxt  = cur_off;
    rec_len_nxt = rec_len_r;
    ip_len_nxt  = cur_ip;
    tcp_len_nxt = cur_tcp;
    emit        = 1'b0;
    emit_last   = 1'b0;
    tcp_at      = '0;
    pay_at      = '0;

    unique case (cur_phase)
      PH_FILE: begin
        offset_nxt = off_inc;
        if (off_inc >= FILE_HDR_END) begin
          phase_nxt   = PH_REC;
          offset_nxt  = '0;
          ip_len_nxt  = ctpe_pkg::HDR_LEN_DEFAULT;
          tcp_len_nxt = ctpe_pkg::HDR_LEN_DEFAULT;
        end
      end
      PH_REC: begin
        if (cur_off == '0) begin
          rec_len_nxt = '0;
        end
        // included length, little-endian
        if (cur_off >= ctpe_pkg::INCL_LEN_FIRST && cur_off <= ctpe_pkg::INCL_LEN_LAST) begin
          case (cur_off[1:0])
            2'd0:    rec_len_nxt[7:0]   = s1_byte_r;
            2'd1:    rec_len_nxt[15:8]  = s1_byte_r;
            2'd2:    rec_len_nxt[23:16] = s1_byte_r;
            default: rec_len_nxt[31:24] = s1_byte_r;
          endcase
        end
        offset_nxt = off_inc;
        if (off_inc >= REC_HDR_END) begin
          offset_nxt  = '0;
          ip_len_nxt  = ctpe_pkg::HDR_LEN_DEFAULT;
          tcp_len_nxt = ctpe_pkg::HDR_LEN_DEFAULT;
          // empty record goes straight to the next record header
          phase_nxt   = (rec_len_nxt == '0) ? PH_REC : PH_BODY;
        end
      end
      PH_BODY: begin
        // ip header length from the first ip byte
        if (cur_off == 32'(link_len_r)) begin
          ip_len_nxt = ctpe_pkg::hdr_len_from_nibble(s1_byte_r[3:0]);
        end
        tcp_at = 9'(link_len_r) + 9'(ip_len_nxt);
        // tcp data offset
        if (cur_off == 32'(tcp_at + ctpe_pkg::TCP_DOFF_BYTE)) begin
          tcp_len_nxt = ctpe_pkg::hdr_len_from_nibble(s1_byte_r[7:4]);
        end
        pay_at = tcp_at + 9'(tcp_len_nxt);
        if (cur_off >= 32'(pay_at)) begin
          emit      = 1'b1;
          emit_last = (cur_off == len_m1);
        end
        // end of record
        if (cur_off >= len_m1) begin
          phase_nxt   = PH_REC;
          offset_nxt  = '0;
          ip_len_nxt  = ctpe_pkg::HDR_LEN_DEFAULT;
          tcp_len_nxt = ctpe_pkg::HDR_LEN_DEFAULT;
        end else begin
          offset_nxt = off_inc;
        end
      end
      default: begin
        phase_nxt = PH_FILE;
      end
    endcase

    // capture end closes any open record and rewinds to the file header
    if (s1_end_r) begin
      emit_last   = emit;
      phase_nxt   = PH_FILE;
      offset_nxt  = '0;
      ip_len_nxt  = ctpe_pkg::HDR_LEN_DEFAULT;
      tcp_len_nxt = ctpe_pkg::HDR_LEN_DEFAULT;
    end
  end

  // output register load
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_fire) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_byte_nxt = s1_byte_r;
        out_last_nxt = emit_last;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_len_r  <= ctpe_pkg::LINK_HDR_RESET;
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_FILE;
      offset_r    <= '0;
      rec_len_r   <= '0;
      ip_len_r    <= ctpe_pkg::HDR_LEN_DEFAULT;
      tcp_len_r   <= ctpe_pkg::HDR_LEN_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      link_len_r  <= link_len_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        phase_r   <= phase_nxt;
        offset_r  <= offset_nxt;
        rec_len_r <= rec_len_nxt;
        ip_len_r  <= ip_len_nxt;
        tcp_len_r <= tcp_len_nxt;
      end
    end
    s1_byte_r  <= s1_byte_nxt;
    s1_end_r   <= s1_end_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // checks
  `ASSERT_ALWAYS(a_reset_empty, (!rst_n) |=> (!s1_valid_r && !out_valid_r), "not empty after reset")
  `ASSERT_CLK(a_ip_len_legal, (ip_len_r >= 6'd20 && ip_len_r <= 6'd60 && ip_len_r[1:0] == 2'b00), "ip header length out of range")
  `ASSERT_CLK(a_body_len_nonzero, (phase_r == PH_BODY) |-> (rec_len_r != '0), "record body entered with zero length")
  `ASSERT_CLK(a_emit_loads_out, (s1_fire && emit) |=> out_valid_r, "payload item not presented")
  `ASSERT_CLK(a_end_rewinds, (s1_fire && s1_end_r) |=> (phase_r == PH_FILE && offset_r == '0), "capture end did not rewind parser")

endmodule

FILE: tb/sv/capture_tcp_payload_extractor_checker.sv
// ctpe_payload_checker: watches the capture and payload channels of the extractor
// predicts each payload item from the accepted capture bytes and compares in order
// depends on ctpe_pkg, ctpe_in_if and ctpe_out_if
`timescale 1ns / 1ps

module ctpe_payload_checker (
  input  logic            clk,
  input  logic            rst_n,
  ctpe_in_if              in_mon,
  ctpe_out_if             out_mon,
  input  logic            cfg_wr_en,
  input  ctpe_pkg::byte_t cfg_wr_data,
  output int              mismatch_cnt,
  output int              payload_due_cnt
);

  localparam int unsigned FILE_HDR_BYTES = 24;
  localparam int unsigned REC_HDR_BYTES  = 16;

  typedef enum logic [1:0] {PH_FILE_HDR, PH_REC_HDR, PH_BODY} parse_phase_e;

  typedef struct packed {
    ctpe_pkg::byte_t data;
    logic            last;
  } payload_t;

  // shadow parser state and register copy
  parse_phase_e       parse_state;
  ctpe_pkg::word_t    rec_off;
  ctpe_pkg::word_t    rec_len;
  ctpe_pkg::hdr_len_t ip_len;
  ctpe_pkg::hdr_len_t tcp_len;
  ctpe_pkg::byte_t    link_len;
  int                 errs = 0;

  payload_t payload_due[$];

  // header length in bytes from a word count nibble, short counts taken as five words
  function automatic ctpe_pkg::hdr_len_t words_to_bytes(input logic [3:0] nib);
    ctpe_pkg::hdr_len_t len;
    if (nib < 4'd5) begin
      len = 6'd20;
    end else begin
      len = ctpe_pkg::hdr_len_t'(nib) << 2;
    end
    return len;
  endfunction

  function automatic void begin_record_hdr();
    parse_state = PH_REC_HDR;
    rec_off     = '0;
    ip_len      = 6'd20;
    tcp_len     = 6'd20;
  endfunction

  // one capture byte through the parser; may yield one payload item
  task automatic parse_capture_byte(input ctpe_pkg::byte_t b, input logic cap_end,
                                    output bit has, output payload_t res);
    ctpe_pkg::word_t o;
    longint unsigned lk;
    longint unsigned tcp_at;
    longint unsigned pay_at;
    has = 1'b0;
    res = '0;
    o   = rec_off;
    case (parse_state)
      PH_FILE_HDR: begin
        rec_off = o + 1;
        if (rec_off >= FILE_HDR_BYTES) begin_record_hdr();
      end
      PH_REC_HDR: begin
        if (o == 0) rec_len = '0;
        // included length, little-endian in bytes 8 to 11
        if (o >= 8 && o <= 11) rec_len[o[1:0]*8 +: 8] = b;
        rec_off = o + 1;
        if (rec_off >= REC_HDR_BYTES) begin
          rec_off = '0;
          if (rec_len == 0) begin
            begin_record_hdr();
          end else begin
            parse_state = PH_BODY;
          end
        end
      end
      default: begin
        lk = link_len;
        if (o == lk) ip_len = words_to_bytes(b[3:0]);
        tcp_at = lk + ip_len;
        if (o == tcp_at + 12) tcp_len = words_to_bytes(b[7:4]);
        pay_at = tcp_at + tcp_len;
        if (o >= pay_at) begin
          has      = 1'b1;
          res.data = b;
          res.last = (o == rec_len - 1);
        end
        if (o >= rec_len - 1) begin
          begin_record_hdr();
        end else begin
          rec_off = o + 1;
        end
      end
    endcase
    // capture end closes any open record and restarts at the file header
    if (cap_end) begin
      if (has) res.last = 1'b1;
      parse_state = PH_FILE_HDR;
      rec_off     = '0;
      ip_len      = 6'd20;
      tcp_len     = 6'd20;
    end
  endtask

  // sample both channels and the register port at each rising edge
  always @(posedge clk) begin : watch
    payload_t got;
    payload_t want;
    payload_t pred;
    bit       has;
    if (!rst_n) begin
      parse_state = PH_FILE_HDR;
      rec_off     = '0;
      rec_len     = '0;
      ip_len      = 6'd20;
      tcp_len     = 6'd20;
      link_len    = 8'd14;
      payload_due.delete();
    end else begin
      if (cfg_wr_en) link_len = cfg_wr_data;
      // compare a delivered payload item with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.data = out_mon.payload_byte;
        got.last = out_mon.payload_last;
        if (payload_due.size() == 0) begin
          $display("%0t unexpected payload item: expected none, actual byte %02h last %0b",
                   $time, got.data, got.last);
          errs++;
        end else begin
          want = payload_due.pop_front();
          if (got.data !== want.data) begin
            $display("%0t payload_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, got.data);
            errs++;
          end
          if (got.last !== want.last) begin
            $display("%0t payload_last mismatch: expected %0b, actual %0b",
                     $time, want.last, got.last);
            errs++;
          end
        end
      end
      // predict from an accepted capture byte
      if (in_mon.valid && in_mon.ready) begin
        parse_capture_byte(in_mon.in_byte, in_mon.capture_end, has, pred);
        if (has) payload_due.push_back(pred);
      end
    end
    mismatch_cnt    <= errs;
    payload_due_cnt <= payload_due.size();
  end

endmodule

FILE: tb/sv/capture_tcp_payload_extractor_tb.sv
// capture_tcp_payload_extractor_tb: drives capture streams into the extractor and gives the verdict
// depends on ctpe_pkg, the channel interfaces, the extractor and ctpe_payload_checker
`timescale 1ns / 1ps

module capture_tcp_payload_extractor_tb;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_wr_en;
  ctpe_pkg::byte_t cfg_wr_data;

  ctpe_in_if  in_ch();
  ctpe_out_if out_ch();

  int              mismatches;
  int              pending;
  int              burst_left = 0;
  int              items_sent = 0;
  int              hold_asked = 0;
  int              hold_taken = 0;
  ctpe_pkg::byte_t link_len   = 8'd14;

  capture_tcp_payload_extractor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ctpe_payload_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_cnt    (mismatches),
    .payload_due_cnt (pending)
  );

  always #6 clk = ~clk;

  // overall time limit
  initial begin
    #6_000_000;
    $display("capture_tcp_payload_extractor_tb NOT OK");
    $finish;
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int cyc;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    cyc       = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 4);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 9) != 0);
          3: out_ch.ready <= ($urandom_range(0, 9) == 0);
          default: out_ch.ready <= cyc[2];
        endcase
      end
    end
  end

  function automatic int unsigned hdr_bytes(input logic [3:0] nib);
    return (nib < 4'd5) ? 20 : nib * 4;
  endfunction

  // offer one capture byte, in bursts with random gaps between them
  task automatic send_item(input ctpe_pkg::byte_t b, input logic cap_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.capture_end <= cap_end;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // write the link header length once nothing is in flight
  task automatic set_link_len(input ctpe_pkg::byte_t v);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    link_len = v;
  endtask

  // file header bytes; fewer than 24 ends the capture on the last one
  task automatic send_file_hdr(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(ctpe_pkg::byte_t'($urandom), (n < 24) && (i == n - 1));
    end
  endtask

  // one record: header with included length, then body with ihl and data offset placed;
  // cut nonzero ends the capture after that many bytes, mid_at writes the register mid-body
  task automatic send_record(input ctpe_pkg::word_t len, input logic [3:0] ihl,
                             input logic [3:0] doff,
                             input int unsigned cut, input bit end_here,
                             input int mid_at, input ctpe_pkg::byte_t mid_val);
    longint unsigned total;
    longint unsigned n;
    longint unsigned i;
    longint unsigned o;
    int unsigned     ip;
    ctpe_pkg::byte_t b;
    total = 64'd16 + len;
    n     = (cut != 0) ? cut : total;
    ip    = hdr_bytes(ihl);
    for (i = 0; i < n; i++) begin
      b = ctpe_pkg::byte_t'($urandom);
      if (i >= 8 && i <= 11) b = len[8*(i-8) +: 8];
      if (i >= 16) begin
        o = i - 16;
        if (mid_at >= 0 && o == mid_at) set_link_len(mid_val);
        if (o == link_len) b[3:0] = ihl;
        if (o == link_len + ip + 12) b[7:4] = doff;
      end
      send_item(b, ((cut != 0) || end_here) && (i == n - 1));
    end
  endtask

  // mostly well-formed records, some empty, overrunning or cut short
  task automatic send_random_record(input bit last, output bit ended);
    int unsigned     k;
    int unsigned     hdr;
    int unsigned     cut;
    logic [3:0]      ihl;
    logic [3:0]      doff;
    ctpe_pkg::word_t len;
    k    = $urandom_range(0, 99);
    ihl  = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom);
    doff = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom);
    hdr  = link_len + hdr_bytes(ihl) + hdr_bytes(doff);
    cut  = 0;
    if (k < 70) begin
      len = hdr + (($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24));
    end else if (k < 76) begin
      len = '0;
    end else if (k < 84) begin
      len = $urandom_range(1, hdr);
    end else if (k < 90) begin
      len = $urandom | 32'h0001_0000;
      cut = $urandom_range(1, 16 + hdr + 16);
    end else begin
      len = hdr + $urandom_range(1, 30);
      cut = $urandom_range(1, 16 + len);
    end
    send_record(len, ihl, doff, cut, last, -1, 8'h00);
    ended = last || (cut != 0);
  endtask

  task automatic send_capture(input int nrec);
    bit ended;
    if ($urandom_range(0, 24) == 0) begin
      send_file_hdr($urandom_range(1, 24));
    end else begin
      send_file_hdr(24);
      ended = 1'b0;
      for (int r = 0; r < nrec && !ended; r++) begin
        send_random_record(r == nrec - 1, ended);
      end
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    ctpe_pkg::byte_t link_plan [3];
    int              start;
    int              waited;
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= '0;
    in_ch.capture_end <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset link length, plain record, empty record, clamped and widest headers
    send_file_hdr(24);
    send_record(32'd56, 4'd5, 4'd5, 0, 0, -1, 8'h00);
    send_record(32'd0, 4'd5, 4'd5, 0, 0, -1, 8'h00);
    send_record(32'd55, 4'd0, 4'd3, 0, 0, -1, 8'h00);
    send_record(32'd135, 4'd15, 4'd15, 0, 0, -1, 8'h00);
    // headers reach or pass the record end
    send_record(32'd54, 4'd5, 4'd5, 0, 0, -1, 8'h00);
    send_record(32'd40, 4'd5, 4'd5, 0, 0, -1, 8'h00);
    // capture end inside the payload closes the record
    send_record(32'd64, 4'd5, 4'd5, 16 + 57, 0, -1, 8'h00);
    // register write in the middle of a record body
    send_file_hdr(24);
    send_record(32'd73, 4'd5, 4'd5, 0, 1, 2, 8'd30);
    // capture end inside the file header and inside a record header
    send_file_hdr(5);
    send_file_hdr(24);
    send_record(32'd100, 4'd5, 4'd5, 10, 0, -1, 8'h00);
    // largest included length, cut short after some payload
    send_file_hdr(24);
    send_record(32'hFFFF_FFFF, 4'd5, 4'd5, 16 + 30 + 40 + 5, 0, -1, 8'h00);

    // random captures over several link header lengths
    link_plan[0] = 8'd0;
    link_plan[1] = 8'd255;
    link_plan[2] = ctpe_pkg::byte_t'($urandom_range(1, 40));
    for (int p = 0; p < 3; p++) begin
      set_link_len(link_plan[p]);
      if (p != 1) hold_asked++;
      start = items_sent;
      while (items_sent - start < 60) send_capture(1);
    end

    // drain
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("capture_tcp_payload_extractor_tb OK");
    end else begin
      $display("capture_tcp_payload_extractor_tb NOT OK");
    end
    $finish;
  end

endmodule
